FILE: design/bilinear_image_scaler_top_macros.svh
// Assertion macros for the bilinear image scaler.
// No dependencies; modules that use them must have clk and rst_n in scope.
`ifndef BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`ifndef SYNTH
`define BIS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BIS_ASSERT_NEXT(name, cond, res, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);
`else
`define BIS_ASSERT(name, prop, msg)
`define BIS_ASSERT_NEXT(name, cond, res, msg)
`endif
`endif

FILE: design/bis_pkg.sv
// Shared constants, codes and stage structs for the bilinear image scaler.
// No dependencies.
package bis_pkg;

    localparam int STORE_DEPTH = 4194304;
    localparam int MAX_WIDTH   = 1024;
    localparam int FRAC_BITS   = 8;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int LOAD_W     = 22;
    localparam int SAMPLE_W   = 8;
    localparam int COORD_W    = 12;
    localparam int STEP_W     = 16;
    localparam int DIM_W      = 11;
    localparam int CH_W       = 3;
    localparam int CHAN_IN_W  = 2;
    localparam int POS_W      = COORD_W + STEP_W;
    localparam int IP_W       = POS_W - FRAC_BITS;
    localparam int ROW_W      = 2 * DIM_W;
    localparam int LIN_W      = ROW_W + 1 + CH_W;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int H_W        = SAMPLE_W + WGT_W + 1;
    localparam int SUM_W      = H_W + WGT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PRODUCE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_CHANNELS   = 2'd2,
        CFG_STEP       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [CH_W-1:0]   chans;
        logic [STEP_W-1:0] step;
    } cfg_t;

    typedef struct packed {
        logic                        valid;
        logic                        is_load;
        logic                        wr_ok;
        logic [ADDR_W-1:0]           wr_addr;
        logic [SAMPLE_W-1:0]         wr_data;
        logic [3:0][ADDR_W-1:0]      rd_addr;
        logic [FRAC_BITS-1:0]        fx;
        logic [FRAC_BITS-1:0]        fy;
        logic                        clamped;
    } req_t;

    typedef struct packed {
        logic                        valid;
        logic [3:0][SAMPLE_W-1:0]    smp;
        logic [FRAC_BITS-1:0]        fx;
        logic [FRAC_BITS-1:0]        fy;
        logic                        clamped;
    } smp_t;

endpackage

FILE: design/bis_addr_gen.sv
// Five-stage front end: position multiply, neighbour locate, row base, sample address.
// Depends on bis_pkg and the assertion macros.
`include "bilinear_image_scaler_top_macros.svh"
module bis_addr_gen
    import bis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic                 opcode,
    input  logic [LOAD_W-1:0]    load_address,
    input  logic [SAMPLE_W-1:0]  load_value,
    input  logic [COORD_W-1:0]   out_x,
    input  logic [COORD_W-1:0]   out_y,
    input  logic [CHAN_IN_W-1:0] channel,
    input  cfg_t                 cfg,
    output req_t                 req
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_load_reg, s2_load_reg, s3_load_reg, s4_load_reg, s5_load_reg;
    logic s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg, s5_ok_reg;
    logic [ADDR_W-1:0]   s1_wa_reg, s2_wa_reg, s3_wa_reg, s4_wa_reg, s5_wa_reg;
    logic [SAMPLE_W-1:0] s1_wd_reg, s2_wd_reg, s3_wd_reg, s4_wd_reg, s5_wd_reg;
    logic [CH_W-1:0]     s1_c_reg, s2_c_reg, s3_c_reg, s4_c_reg;
    logic [COORD_W-1:0]  s1_x_reg, s1_y_reg;
    logic [POS_W-1:0]    s2_px_reg, s2_py_reg;
    logic [DIM_W-1:0]    s3_x0_reg, s3_x1_reg, s3_y0_reg, s3_y1_reg;
    logic [DIM_W-1:0]    s4_x0_reg, s4_x1_reg;
    logic [ROW_W-1:0]    s4_r0_reg, s4_r1_reg;
    logic [FRAC_BITS-1:0] s3_fx_reg, s3_fy_reg, s4_fx_reg, s4_fy_reg, s5_fx_reg, s5_fy_reg;
    logic s3_cl_reg, s4_cl_reg, s5_cl_reg;
    logic [3:0][ADDR_W-1:0] s5_ra_reg;

    logic [CH_W-1:0]  c_next;
    logic [POS_W-1:0] px_next, py_next;
    logic [IP_W-1:0]  ipx, ipy;
    logic [IP_W:0]    ipx_hi, ipy_hi;
    logic [DIM_W-1:0] x0_next, x1_next, y0_next, y1_next;
    logic             cl_next;
    logic [3:0][ADDR_W-1:0] ra_next;

    function automatic logic [ADDR_W-1:0] lin_addr(
        input logic [ROW_W-1:0] row,
        input logic [DIM_W-1:0] col,
        input logic [CH_W-1:0]  chans,
        input logic [CH_W-1:0]  c
    );
        logic [ROW_W:0] pix;
        logic [LIN_W-1:0] lin;
        pix = {1'b0, row} + {{(ROW_W - DIM_W + 1){1'b0}}, col};
        lin = LIN_W'(pix) * LIN_W'(chans) + LIN_W'(c);
        return ADDR_W'(lin);
    endfunction

    always_comb
    begin
        c_next = ({1'b0, channel} >= cfg.chans) ? CH_W'(cfg.chans - 1'b1) : {1'b0, channel};
        px_next = POS_W'(s1_x_reg) * POS_W'(cfg.step);
        py_next = POS_W'(s1_y_reg) * POS_W'(cfg.step);
        ipx = s2_px_reg[POS_W-1:FRAC_BITS];
        ipy = s2_py_reg[POS_W-1:FRAC_BITS];
        ipx_hi = {1'b0, ipx} + 1'b1;
        ipy_hi = {1'b0, ipy} + 1'b1;
        cl_next = 1'b0;
        x0_next = DIM_W'(ipx);
        x1_next = DIM_W'(ipx_hi);
        y0_next = DIM_W'(ipy);
        y1_next = DIM_W'(ipy_hi);
        if (ipx >= IP_W'(cfg.width))
        begin
            x0_next = cfg.width - 1'b1;
            cl_next = 1'b1;
        end
        if (ipx_hi >= (IP_W+1)'(cfg.width))
        begin
            x1_next = cfg.width - 1'b1;
            cl_next = 1'b1;
        end
        if (ipy >= IP_W'(cfg.height))
        begin
            y0_next = cfg.height - 1'b1;
            cl_next = 1'b1;
        end
        if (ipy_hi >= (IP_W+1)'(cfg.height))
        begin
            y1_next = cfg.height - 1'b1;
            cl_next = 1'b1;
        end
        ra_next[0] = lin_addr(s4_r0_reg, s4_x0_reg, cfg.chans, s4_c_reg);
        ra_next[1] = lin_addr(s4_r0_reg, s4_x1_reg, cfg.chans, s4_c_reg);
        ra_next[2] = lin_addr(s4_r1_reg, s4_x0_reg, cfg.chans, s4_c_reg);
        ra_next[3] = lin_addr(s4_r1_reg, s4_x1_reg, cfg.chans, s4_c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_load_reg <= (opcode == OP_LOAD);
            s1_ok_reg   <= (32'(load_address) < STORE_DEPTH);
            s1_wa_reg   <= ADDR_W'(load_address);
            s1_wd_reg   <= load_value;
            s1_x_reg    <= out_x;
            s1_y_reg    <= out_y;
            s1_c_reg    <= c_next;

            s2_load_reg <= s1_load_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_wa_reg   <= s1_wa_reg;
            s2_wd_reg   <= s1_wd_reg;
            s2_c_reg    <= s1_c_reg;
            s2_px_reg   <= px_next;
            s2_py_reg   <= py_next;

            s3_load_reg <= s2_load_reg;
            s3_ok_reg   <= s2_ok_reg;
            s3_wa_reg   <= s2_wa_reg;
            s3_wd_reg   <= s2_wd_reg;
            s3_c_reg    <= s2_c_reg;
            s3_x0_reg   <= x0_next;
            s3_x1_reg   <= x1_next;
            s3_y0_reg   <= y0_next;
            s3_y1_reg   <= y1_next;
            s3_fx_reg   <= s2_px_reg[FRAC_BITS-1:0];
            s3_fy_reg   <= s2_py_reg[FRAC_BITS-1:0];
            s3_cl_reg   <= cl_next;

            s4_load_reg <= s3_load_reg;
            s4_ok_reg   <= s3_ok_reg;
            s4_wa_reg   <= s3_wa_reg;
            s4_wd_reg   <= s3_wd_reg;
            s4_c_reg    <= s3_c_reg;
            s4_x0_reg   <= s3_x0_reg;
            s4_x1_reg   <= s3_x1_reg;
            s4_r0_reg   <= ROW_W'(s3_y0_reg) * ROW_W'(cfg.width);
            s4_r1_reg   <= ROW_W'(s3_y1_reg) * ROW_W'(cfg.width);
            s4_fx_reg   <= s3_fx_reg;
            s4_fy_reg   <= s3_fy_reg;
            s4_cl_reg   <= s3_cl_reg;

            s5_load_reg <= s4_load_reg;
            s5_ok_reg   <= s4_ok_reg;
            s5_wa_reg   <= s4_wa_reg;
            s5_wd_reg   <= s4_wd_reg;
            s5_ra_reg   <= ra_next;
            s5_fx_reg   <= s4_fx_reg;
            s5_fy_reg   <= s4_fy_reg;
            s5_cl_reg   <= s4_cl_reg;
        end
    end

    assign req.valid   = s5_valid_reg;
    assign req.is_load = s5_load_reg;
    assign req.wr_ok   = s5_ok_reg;
    assign req.wr_addr = s5_wa_reg;
    assign req.wr_data = s5_wd_reg;
    assign req.rd_addr = s5_ra_reg;
    assign req.fx      = s5_fx_reg;
    assign req.fy      = s5_fy_reg;
    assign req.clamped = s5_cl_reg;

    `BIS_ASSERT(a_x1_in_frame, s3_valid_reg && !s3_load_reg |-> s3_x1_reg < cfg.width, "x1 out of frame")
    `BIS_ASSERT(a_y1_in_frame, s3_valid_reg && !s3_load_reg |-> s3_y1_reg < cfg.height, "y1 out of frame")
    `BIS_ASSERT_NEXT(a_stall_holds, !advance, $stable(s5_valid_reg) && $stable(s5_ra_reg), "stall moved s5")

endmodule

FILE: design/bis_store.sv
// Frame store: two identical banks, one write and two registered reads each per advance.
// Depends on bis_pkg.
module bis_store
    import bis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  req_t req,
    output smp_t smp
);

    logic [SAMPLE_W-1:0] bank0_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] bank1_mem [STORE_DEPTH];
    logic [3:0][SAMPLE_W-1:0] rd_reg;
    logic valid_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic cl_reg;
    logic wr_en;

    assign wr_en = advance && req.valid && req.is_load && req.wr_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank0_mem[req.wr_addr] <= req.wr_data;
        end
        if (advance)
        begin
            rd_reg[0] <= bank0_mem[req.rd_addr[0]];
            rd_reg[1] <= bank0_mem[req.rd_addr[1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank1_mem[req.wr_addr] <= req.wr_data;
        end
        if (advance)
        begin
            rd_reg[2] <= bank1_mem[req.rd_addr[2]];
            rd_reg[3] <= bank1_mem[req.rd_addr[3]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req.valid && !req.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fx_reg <= req.fx;
            fy_reg <= req.fy;
            cl_reg <= req.clamped;
        end
    end

    assign smp.valid   = valid_reg;
    assign smp.smp     = rd_reg;
    assign smp.fx      = fx_reg;
    assign smp.fy      = fy_reg;
    assign smp.clamped = cl_reg;

endmodule

FILE: design/bis_blend.sv
// Two-stage blend: horizontal mix of both rows, then vertical mix into the output register.
// Depends on bis_pkg and the assertion macros.
`include "bilinear_image_scaler_top_macros.svh"
module bis_blend
    import bis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  smp_t                smp,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] pixel,
    output logic                clamped
);

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    logic s7_valid_reg, s8_valid_reg;
    logic [H_W-1:0] h0_reg, h1_reg;
    logic [FRAC_BITS-1:0] fy_reg;
    logic s7_cl_reg, s8_cl_reg;
    logic [SAMPLE_W-1:0] pix_reg;

    logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
    logic [H_W-1:0]   h0_next, h1_next;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] pix_wide;
    logic [SAMPLE_W-1:0] pix_next;

    always_comb
    begin
        wx1 = WGT_W'(smp.fx);
        wx0 = ONE - wx1;
        wy1 = WGT_W'(fy_reg);
        wy0 = ONE - wy1;
        h0_next = H_W'(smp.smp[0]) * H_W'(wx0) + H_W'(smp.smp[1]) * H_W'(wx1);
        h1_next = H_W'(smp.smp[2]) * H_W'(wx0) + H_W'(smp.smp[3]) * H_W'(wx1);
        sum = SUM_W'(h0_reg) * SUM_W'(wy0) + SUM_W'(h1_reg) * SUM_W'(wy1);
        pix_wide = sum >> (2 * FRAC_BITS);
        pix_next = (pix_wide > SUM_W'(255)) ? 8'hFF : SAMPLE_W'(pix_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s7_valid_reg <= smp.valid;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h0_reg    <= h0_next;
            h1_reg    <= h1_next;
            fy_reg    <= smp.fy;
            s7_cl_reg <= smp.clamped;
            pix_reg   <= pix_next;
            s8_cl_reg <= s7_cl_reg;
        end
    end

    assign out_valid = s8_valid_reg;
    assign pixel     = pix_reg;
    assign clamped   = s8_cl_reg;

    `BIS_ASSERT_NEXT(a_result_lands, advance && s7_valid_reg, s8_valid_reg, "result lost")
    `BIS_ASSERT_NEXT(a_no_phantom, advance && !s7_valid_reg, !s8_valid_reg, "phantom result")

endmodule

FILE: design/bilinear_image_scaler_top.sv
// Top level of the bilinear image scaler: configuration registers and pipeline wiring.
// Depends on bis_pkg, bis_addr_gen, bis_store and bis_blend.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready     opcode load_address load_value out_x out_y channel
//   out      output     out_valid / out_ready   pixel clamped
//   cfg      input      cfg_valid / cfg_ready   cfg_index cfg_data
//
// One request enters per cycle unless the output stalls; only produce requests yield a result.
// The four neighbour reads use two store banks with two read ports each.
// Reset clears pipeline valid bits and sets default configuration; store contents are undefined.
// A stalled output freezes every stage; in_ready falls with it.
module bilinear_image_scaler_top
    import bis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [LOAD_W-1:0]     load_address,
    input  logic [SAMPLE_W-1:0]   load_value,
    input  logic [COORD_W-1:0]    out_x,
    input  logic [COORD_W-1:0]    out_y,
    input  logic [CHAN_IN_W-1:0]  channel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   pixel,
    output logic                  clamped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [CH_W-1:0]   chans_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIM_W-1:0]  width_lim;
    cfg_t cfg;
    req_t req;
    smp_t smp;
    logic advance;

    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            chans_reg  <= CH_W'(1);
            step_reg   <= STEP_W'(256);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SRC_WIDTH:  width_reg  <= DIM_W'(cfg_data);
                CFG_SRC_HEIGHT: height_reg <= DIM_W'(cfg_data);
                CFG_CHANNELS:   chans_reg  <= CH_W'(cfg_data);
                CFG_STEP:       step_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        width_lim = (width_reg == '0) ? DIM_W'(1) : width_reg;
        if (32'(width_lim) > MAX_WIDTH)
        begin
            width_lim = DIM_W'(MAX_WIDTH);
        end
        cfg.width  = width_lim;
        cfg.height = (height_reg == '0) ? DIM_W'(1) : height_reg;
        cfg.chans  = (chans_reg == '0) ? CH_W'(1) : chans_reg;
        cfg.step   = step_reg;
    end

    bis_addr_gen u_addr_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .opcode       (opcode),
        .load_address (load_address),
        .load_value   (load_value),
        .out_x        (out_x),
        .out_y        (out_y),
        .channel      (channel),
        .cfg          (cfg),
        .req          (req)
    );

    bis_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .smp     (smp)
    );

    bis_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .smp       (smp),
        .out_valid (out_valid),
        .pixel     (pixel),
        .clamped   (clamped)
    );

endmodule
